FILE: src/lscs_pkg.sv
`default_nettype none

package lscs_pkg;

   localparam int NUM_SENSORS = 8;
   localparam int SAMPLE_MAX  = 1023;
   localparam int SAMPLE_W    = 10;
   localparam int CSR_DATA_W  = 10;
   localparam int CSR_INDEX_W = 3;

   localparam logic [SAMPLE_W-1:0] MIN_RESET       = SAMPLE_W'(SAMPLE_MAX);
   localparam logic [SAMPLE_W-1:0] MAX_RESET       = '0;
   localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 10'd500;

   localparam logic [7:0] BASE_SPEED_RESET = 8'd100;

   localparam logic signed [9:0] CMD_BACK = -10'sd40;
   localparam logic signed [9:0] CMD_SOFT = 10'sd80;
   localparam logic signed [9:0] CMD_FULL = 10'sd100;

   localparam logic signed [10:0] DUTY_LIMIT = 11'sd255;

   typedef enum logic [2:0] {
      KIND_CLEAR   = 3'd0,
      KIND_SAMPLE  = 3'd1,
      KIND_FINISH  = 3'd2,
      KIND_FOLLOW  = 3'd3,
      KIND_RESTORE = 3'd4
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BASE_SPEED        = 3'd0,
      CSR_LEFT_TRIM         = 3'd1,
      CSR_RIGHT_TRIM        = 3'd2,
      CSR_JUNCTION_STOP     = 3'd3,
      CSR_DEFAULT_THRESHOLD = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_BRAKE   = 2'd0,
      MODE_FORWARD = 2'd1,
      MODE_REVERSE = 2'd2
   } wheel_mode_type;

   typedef struct packed {
      logic [7:0]        base_speed;
      logic signed [8:0] left_trim;
      logic signed [8:0] right_trim;
      logic              junction_stop;
   } steer_cfg_type;

   typedef struct packed {
      wheel_mode_type mode;
      logic [7:0]     duty;
   } wheel_type;

   typedef struct packed {
      wheel_type left;
      wheel_type right;
      logic      junction;
   } result_type;

endpackage

`default_nettype wire

FILE: src/line_sensor_calibrate_and_steer.sv
// Line sensor calibration and steering.
// Request channel (req_valid/req_ready) carries a kind code and eight
// reflectance samples, sensor 1 leftmost. Every item gives exactly one
// item on the response channel (rsp_valid/rsp_ready): wheel mode and duty
// for each side and a junction flag; non-follow kinds return all zero.
// Each sensor has its own lane holding min, max and threshold; the lanes
// compare in parallel and the steering stage merges their seen bits.
// The result is in the output register from the cycle after accept.
// Throughput: one item per cycle while rsp_ready is high, set by the single output register;
// a new item is taken in the cycle the held result leaves.
// Receiver stall: the result holds in place and req_ready drops until
// rsp_ready returns.
// Reset: min 1023, max 0, thresholds 500, registers to their defaults,
// no response pending. Registers on the csr_ port apply from the next item.
`default_nettype none

module line_sensor_calibrate_and_steer
   import lscs_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire logic [2:0]             req_kind,
   input  wire logic [SAMPLE_W-1:0]    req_sensor_1,
   input  wire logic [SAMPLE_W-1:0]    req_sensor_2,
   input  wire logic [SAMPLE_W-1:0]    req_sensor_3,
   input  wire logic [SAMPLE_W-1:0]    req_sensor_4,
   input  wire logic [SAMPLE_W-1:0]    req_sensor_5,
   input  wire logic [SAMPLE_W-1:0]    req_sensor_6,
   input  wire logic [SAMPLE_W-1:0]    req_sensor_7,
   input  wire logic [SAMPLE_W-1:0]    req_sensor_8,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      logic [1:0]             rsp_left_mode,
   output      logic [7:0]             rsp_left_duty,
   output      logic [1:0]             rsp_right_mode,
   output      logic [7:0]             rsp_right_duty,
   output      logic                   rsp_junction,
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [7:0]          base_speed_ff, base_speed_in;
   logic signed [8:0]   left_trim_ff, left_trim_in;
   logic signed [8:0]   right_trim_ff, right_trim_in;
   logic                junction_stop_ff, junction_stop_in;
   logic [SAMPLE_W-1:0] default_threshold_ff, default_threshold_in;

   logic                   accept;
   kind_type               kind;
   logic [SAMPLE_W-1:0]    sample [NUM_SENSORS];
   logic [NUM_SENSORS-1:0] seen;
   steer_cfg_type          cfg;
   result_type             rsp;

   assign accept = req_valid && req_ready;
   assign kind   = kind_type'(req_kind);

   assign sample[0] = req_sensor_1;
   assign sample[1] = req_sensor_2;
   assign sample[2] = req_sensor_3;
   assign sample[3] = req_sensor_4;
   assign sample[4] = req_sensor_5;
   assign sample[5] = req_sensor_6;
   assign sample[6] = req_sensor_7;
   assign sample[7] = req_sensor_8;

   always_comb begin
      base_speed_in        = base_speed_ff;
      left_trim_in         = left_trim_ff;
      right_trim_in        = right_trim_ff;
      junction_stop_in     = junction_stop_ff;
      default_threshold_in = default_threshold_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_BASE_SPEED:        base_speed_in        = csr_wdata[7:0];
            CSR_LEFT_TRIM:         left_trim_in         = $signed(csr_wdata[8:0]);
            CSR_RIGHT_TRIM:        right_trim_in        = $signed(csr_wdata[8:0]);
            CSR_JUNCTION_STOP:     junction_stop_in     = csr_wdata[0];
            CSR_DEFAULT_THRESHOLD: default_threshold_in = csr_wdata[SAMPLE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_speed_ff        <= BASE_SPEED_RESET;
         left_trim_ff         <= '0;
         right_trim_ff        <= '0;
         junction_stop_ff     <= 1'b1;
         default_threshold_ff <= THRESHOLD_RESET;
      end else begin
         base_speed_ff        <= base_speed_in;
         left_trim_ff         <= left_trim_in;
         right_trim_ff        <= right_trim_in;
         junction_stop_ff     <= junction_stop_in;
         default_threshold_ff <= default_threshold_in;
      end
   end

   for (genvar i = 0; i < NUM_SENSORS; i++) begin : g_lane
      lscs_lane u_lane (
         .clock             (clock),
         .reset             (reset),
         .accept            (accept),
         .kind              (kind),
         .sample            (sample[i]),
         .default_threshold (default_threshold_ff),
         .seen              (seen[i])
      );
   end

   assign cfg.base_speed    = base_speed_ff;
   assign cfg.left_trim     = left_trim_ff;
   assign cfg.right_trim    = right_trim_ff;
   assign cfg.junction_stop = junction_stop_ff;

   lscs_steer u_steer (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .kind      (kind),
      .seen      (seen),
      .cfg       (cfg),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .req_ready (req_ready)
   );

   assign rsp_left_mode  = rsp.left.mode;
   assign rsp_left_duty  = rsp.left.duty;
   assign rsp_right_mode = rsp.right.mode;
   assign rsp_right_duty = rsp.right.duty;
   assign rsp_junction   = rsp.junction;

endmodule

`default_nettype wire

FILE: src/lscs_lane.sv
`default_nettype none

module lscs_lane
   import lscs_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire kind_type            kind,
   input  wire logic [SAMPLE_W-1:0] sample,
   input  wire logic [SAMPLE_W-1:0] default_threshold,
   output      logic                seen
);

   logic [SAMPLE_W-1:0] min_ff, min_in;
   logic [SAMPLE_W-1:0] max_ff, max_in;
   logic [SAMPLE_W-1:0] threshold_ff, threshold_in;
   logic [SAMPLE_W:0]   mid_sum;

   assign mid_sum = {1'b0, min_ff} + {1'b0, max_ff};
   assign seen    = sample < threshold_ff;

   always_comb begin
      min_in       = min_ff;
      max_in       = max_ff;
      threshold_in = threshold_ff;
      if (accept) begin
         unique case (kind)
            KIND_CLEAR: begin
               min_in = MIN_RESET;
               max_in = MAX_RESET;
            end
            KIND_SAMPLE: begin
               if (sample < min_ff) min_in = sample;
               if (sample > max_ff) max_in = sample;
            end
            KIND_FINISH:  threshold_in = mid_sum[SAMPLE_W:1];
            KIND_RESTORE: threshold_in = default_threshold;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff       <= MIN_RESET;
         max_ff       <= MAX_RESET;
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         min_ff       <= min_in;
         max_ff       <= max_in;
         threshold_ff <= threshold_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/lscs_steer.sv
`default_nettype none

module lscs_steer
   import lscs_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  wire kind_type               kind,
   input  wire logic [NUM_SENSORS-1:0] seen,
   input  wire steer_cfg_type          cfg,
   input  wire logic                   rsp_ready,
   output      logic                   rsp_valid,
   output      result_type             rsp,
   output      logic                   req_ready
);

   function automatic wheel_type drive(logic signed [9:0] cmd, logic signed [8:0] trim);
      logic signed [10:0] cmd_x;
      logic signed [10:0] trim_x;
      logic signed [10:0] v;
      logic signed [10:0] neg;
      wheel_type          w;
      cmd_x  = 11'(cmd);
      trim_x = 11'(trim);
      if (cmd > 10'sd0)      v = cmd_x + trim_x;
      else if (cmd < 10'sd0) v = cmd_x - trim_x;
      else                   v = '0;
      if (v > DUTY_LIMIT)  v = DUTY_LIMIT;
      if (v < -DUTY_LIMIT) v = -DUTY_LIMIT;
      neg = -v;
      if (v > 11'sd0) begin
         w.mode = MODE_FORWARD;
         w.duty = v[7:0];
      end else if (v < 11'sd0) begin
         w.mode = MODE_REVERSE;
         w.duty = neg[7:0];
      end else begin
         w.mode = MODE_BRAKE;
         w.duty = '0;
      end
      return w;
   endfunction

   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff, rsp_in;
   logic signed [9:0] base_cmd;
   logic signed [9:0] left_cmd;
   logic signed [9:0] right_cmd;
   logic              junction_seen;
   logic              junction_flag;

   assign req_ready     = !rsp_valid_ff || rsp_ready;
   assign base_cmd      = $signed({2'b00, cfg.base_speed});
   assign junction_seen = (seen[0] && seen[1]) || (seen[6] && seen[7]);

   always_comb begin
      junction_flag = 1'b0;
      if (junction_seen) begin
         if (cfg.junction_stop) begin
            left_cmd      = CMD_FULL;
            right_cmd     = CMD_FULL;
            junction_flag = 1'b1;
         end else begin
            left_cmd  = base_cmd;
            right_cmd = base_cmd;
         end
      end else if (seen[1]) begin
         left_cmd  = CMD_BACK;
         right_cmd = CMD_FULL;
      end else if (seen[2]) begin
         left_cmd  = CMD_SOFT;
         right_cmd = CMD_FULL;
      end else if (seen[5]) begin
         left_cmd  = CMD_FULL;
         right_cmd = CMD_SOFT;
      end else if (seen[6]) begin
         left_cmd  = CMD_FULL;
         right_cmd = CMD_BACK;
      end else begin
         left_cmd  = base_cmd;
         right_cmd = base_cmd;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         if (kind == KIND_FOLLOW) begin
            rsp_in.left     = drive(left_cmd, cfg.left_trim);
            rsp_in.right    = drive(right_cmd, cfg.right_trim);
            rsp_in.junction = junction_flag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire
